[hdl/jap_pkg.sv]
// ----------------------------------------------------------------------------
// jap_pkg
// shared constants, types and helpers of the joystick axis pair detector
// ----------------------------------------------------------------------------
`default_nettype none

package jap_pkg;

   localparam int DEF_WINDOW   = 1000;
   localparam int DEF_MAX_AXES = 8;
   localparam int LANES        = 8;
   localparam int SAMPLE_W     = 16;
   localparam int MAG_W        = SAMPLE_W + 1;
   localparam int COUNT_W      = 4;
   localparam int AXIS_W       = 4;

   localparam logic signed [AXIS_W-1:0] AXIS_NONE = -4'sd1;

   typedef struct packed {
      logic update;
      logic push;
      logic clear;
      logic drop;
   } sum_ctrl_type;

   function automatic logic [MAG_W-1:0] mag16(input logic [SAMPLE_W-1:0] v);
      logic [MAG_W-1:0] m;
      if (v[SAMPLE_W-1]) begin
         m = {1'b0, ~v} + MAG_W'(1);
      end else begin
         m = {1'b0, v};
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[hdl/joystick_axis_pair_detector_unit.sv]
// ----------------------------------------------------------------------------
// joystick_axis_pair_detector_unit
// finds the calibrated odd/even axis pair from a window of joystick rows
// ----------------------------------------------------------------------------
// usage:
//   a row of axis samples and an axis count is taken as a transaction when
//   start is high and busy is low. in a transaction the idle cycle reads the
//   oldest window row from the row memory, and the update cycle writes the
//   new row and updates the per-axis sums. busy is high for the update
//   cycle, so no new row is taken until the update cycle is over.
//   a row whose valid axes are all zero ends a gesture; if rows are stored
//   the strongest odd and even axes are picked, and the held pair appears
//   on rsp_first_axis / rsp_second_axis with rsp_valid high for one cycle,
//   right after the update cycle.
//   the receiver cannot stall; the result register is free again before
//   the next transaction can produce a result.
//   reset clears the sums, the row count and the write slot, and sets the
//   held pair to -1. the row memory itself is not cleared: only slots
//   written since the last clear are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_axis_pair_detector_unit
   import jap_pkg::*;
#(
   parameter int WINDOW   = DEF_WINDOW,
   parameter int MAX_AXES = DEF_MAX_AXES
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire signed [SAMPLE_W-1:0]     req_axis_value_0,
   input  wire signed [SAMPLE_W-1:0]     req_axis_value_1,
   input  wire signed [SAMPLE_W-1:0]     req_axis_value_2,
   input  wire signed [SAMPLE_W-1:0]     req_axis_value_3,
   input  wire signed [SAMPLE_W-1:0]     req_axis_value_4,
   input  wire signed [SAMPLE_W-1:0]     req_axis_value_5,
   input  wire signed [SAMPLE_W-1:0]     req_axis_value_6,
   input  wire signed [SAMPLE_W-1:0]     req_axis_value_7,
   input  wire [COUNT_W-1:0]             req_axis_count,
   output logic                          rsp_valid,
   output logic signed [AXIS_W-1:0]      rsp_first_axis,
   output logic signed [AXIS_W-1:0]      rsp_second_axis
);

   localparam int ROW_W  = MAX_AXES * SAMPLE_W;
   localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int RH_W   = $clog2(WINDOW + 1);
   localparam int SUM_W  = SAMPLE_W - 1 + $clog2(WINDOW + 1);

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type                  state_ff;
   logic [ROW_W-1:0]           row_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic                       clear_ff;
   logic [COUNT_W-1:0]         held_count_ff;
   logic [RH_W-1:0]            rows_held_ff;
   logic [ADDR_W-1:0]          write_slot_ff;
   logic signed [AXIS_W-1:0]   pair_low_ff;
   logic signed [AXIS_W-1:0]   pair_high_ff;
   logic                       rsp_valid_ff;
   logic signed [AXIS_W-1:0]   rsp_first_ff;
   logic signed [AXIS_W-1:0]   rsp_second_ff;

   logic [SAMPLE_W-1:0]        lane_in [LANES];
   logic [COUNT_W-1:0]         count_sat;
   logic [ROW_W-1:0]           row_in;
   logic                       accept;
   logic                       clear_now;
   logic [ADDR_W-1:0]          rd_addr;
   logic [ROW_W-1:0]           old_row;

   logic                       any;
   logic [RH_W-1:0]            rows_eff;
   logic [ADDR_W-1:0]          slot_eff;
   logic                       full;
   logic [ADDR_W-1:0]          slot_next;
   logic                       emit;
   sum_ctrl_type               sum_ctrl;
   logic [SUM_W-1:0]           sums [MAX_AXES];
   logic                       pick_found;
   logic signed [AXIS_W-1:0]   pick_low;
   logic signed [AXIS_W-1:0]   pick_high;
   logic signed [AXIS_W-1:0]   pair_low_in;
   logic signed [AXIS_W-1:0]   pair_high_in;

   assign lane_in[0] = req_axis_value_0;
   assign lane_in[1] = req_axis_value_1;
   assign lane_in[2] = req_axis_value_2;
   assign lane_in[3] = req_axis_value_3;
   assign lane_in[4] = req_axis_value_4;
   assign lane_in[5] = req_axis_value_5;
   assign lane_in[6] = req_axis_value_6;
   assign lane_in[7] = req_axis_value_7;

   assign count_sat = (req_axis_count > COUNT_W'(MAX_AXES)) ? COUNT_W'(MAX_AXES)
                                                            : req_axis_count;

   always_comb begin
      for (int i = 0; i < MAX_AXES; i++) begin
         row_in[i*SAMPLE_W +: SAMPLE_W] = (COUNT_W'(i) < count_sat) ? lane_in[i] : '0;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign clear_now = (count_sat != held_count_ff);
   assign rd_addr   = clear_now ? '0 : write_slot_ff;

   // update cycle
   assign any       = |row_ff;
   assign rows_eff  = clear_ff ? '0 : rows_held_ff;
   assign slot_eff  = clear_ff ? '0 : write_slot_ff;
   assign full      = (rows_eff >= RH_W'(WINDOW));
   assign slot_next = (slot_eff == ADDR_W'(WINDOW - 1)) ? '0 : slot_eff + ADDR_W'(1);
   assign emit      = (state_ff == ST_UPDATE) && !any && (rows_eff != '0);

   assign sum_ctrl.update = (state_ff == ST_UPDATE);
   assign sum_ctrl.push   = any;
   assign sum_ctrl.clear  = clear_ff;
   assign sum_ctrl.drop   = full;

   assign pair_low_in  = pick_found ? pick_low : pair_low_ff;
   assign pair_high_in = pick_found ? pick_high : pair_high_ff;

   jap_row_mem #(
      .WINDOW (WINDOW),
      .ROW_W  (ROW_W),
      .ADDR_W (ADDR_W)
   ) u_row_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (old_row),
      .wr_en   ((state_ff == ST_UPDATE) && any),
      .wr_addr (slot_eff),
      .wr_data (row_ff)
   );

   jap_sums #(
      .MAX_AXES (MAX_AXES),
      .SUM_W    (SUM_W)
   ) u_sums (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (sum_ctrl),
      .new_row (row_ff),
      .old_row (old_row),
      .sums    (sums)
   );

   jap_pick #(
      .MAX_AXES (MAX_AXES),
      .SUM_W    (SUM_W)
   ) u_pick (
      .sums      (sums),
      .count     (count_ff),
      .found     (pick_found),
      .pair_low  (pick_low),
      .pair_high (pick_high)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clear_ff      <= 1'b0;
         held_count_ff <= '0;
         rows_held_ff  <= '0;
         write_slot_ff <= '0;
         pair_low_ff   <= AXIS_NONE;
         pair_high_ff  <= AXIS_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  row_ff        <= row_in;
                  count_ff      <= count_sat;
                  clear_ff      <= clear_now;
                  held_count_ff <= count_sat;
                  state_ff      <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (any) begin
                  rows_held_ff  <= full ? rows_eff : rows_eff + RH_W'(1);
                  write_slot_ff <= slot_next;
               end else begin
                  rows_held_ff  <= '0;
                  write_slot_ff <= '0;
               end
               if (emit) begin
                  pair_low_ff   <= pair_low_in;
                  pair_high_ff  <= pair_high_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_first_ff  <= pair_low_in;
                  rsp_second_ff <= pair_high_in;
               end
               clear_ff <= 1'b0;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_axis  = rsp_first_ff;
   assign rsp_second_axis = rsp_second_ff;

endmodule

`default_nettype wire

[hdl/jap_row_mem.sv]
// ----------------------------------------------------------------------------
// jap_row_mem
// window of stored rows, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module jap_row_mem
   import jap_pkg::*;
#(
   parameter int WINDOW = DEF_WINDOW,
   parameter int ROW_W  = DEF_MAX_AXES * SAMPLE_W,
   parameter int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
   input  wire              clock,
   input  wire              rd_en,
   input  wire [ADDR_W-1:0] rd_addr,
   output logic [ROW_W-1:0] rd_data,
   input  wire              wr_en,
   input  wire [ADDR_W-1:0] wr_addr,
   input  wire [ROW_W-1:0]  wr_data
);

   logic [ROW_W-1:0] mem [WINDOW];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/jap_sums.sv]
// ----------------------------------------------------------------------------
// jap_sums
// per-axis running sums of absolute samples over the window
// ----------------------------------------------------------------------------
`default_nettype none

module jap_sums
   import jap_pkg::*;
#(
   parameter int MAX_AXES = DEF_MAX_AXES,
   parameter int SUM_W    = 25
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire sum_ctrl_type              ctrl,
   input  wire [MAX_AXES*SAMPLE_W-1:0]    new_row,
   input  wire [MAX_AXES*SAMPLE_W-1:0]    old_row,
   output logic [SUM_W-1:0]               sums [MAX_AXES]
);

   logic [SUM_W-1:0] sums_ff [MAX_AXES];
   logic [SUM_W-1:0] sums_in [MAX_AXES];

   always_comb begin
      logic [SUM_W-1:0] base;
      logic [SUM_W-1:0] old_mag;
      logic [SUM_W-1:0] new_mag;
      for (int i = 0; i < MAX_AXES; i++) begin
         base    = ctrl.clear ? '0 : sums_ff[i];
         old_mag = ctrl.drop ? SUM_W'(mag16(old_row[i*SAMPLE_W +: SAMPLE_W])) : '0;
         new_mag = SUM_W'(mag16(new_row[i*SAMPLE_W +: SAMPLE_W]));
         if (!ctrl.update) begin
            sums_in[i] = sums_ff[i];
         end else if (ctrl.push) begin
            sums_in[i] = base - old_mag + new_mag;
         end else begin
            sums_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_AXES; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         sums_ff <= sums_in;
      end
   end

   assign sums = sums_ff;

endmodule

`default_nettype wire

[hdl/jap_pick.sv]
// ----------------------------------------------------------------------------
// jap_pick
// strongest odd and even axis, returned as an ascending pair
// ----------------------------------------------------------------------------
`default_nettype none

module jap_pick
   import jap_pkg::*;
#(
   parameter int MAX_AXES = DEF_MAX_AXES,
   parameter int SUM_W    = 25
) (
   input  wire [SUM_W-1:0]           sums [MAX_AXES],
   input  wire [COUNT_W-1:0]         count,
   output logic                      found,
   output logic signed [AXIS_W-1:0]  pair_low,
   output logic signed [AXIS_W-1:0]  pair_high
);

   always_comb begin
      logic [SUM_W-1:0]  best_odd;
      logic [SUM_W-1:0]  best_even;
      logic [AXIS_W-1:0] odd_idx;
      logic [AXIS_W-1:0] even_idx;
      logic              odd_ok;
      logic              even_ok;
      best_odd  = '0;
      best_even = '0;
      odd_idx   = '0;
      even_idx  = '0;
      odd_ok    = 1'b0;
      even_ok   = 1'b0;
      for (int i = 0; i < MAX_AXES; i++) begin
         if (COUNT_W'(i) < count) begin
            if (i % 2 == 1) begin
               if (!odd_ok || sums[i] > best_odd) begin
                  best_odd = sums[i];
                  odd_idx  = AXIS_W'(i);
                  odd_ok   = 1'b1;
               end
            end else begin
               if (!even_ok || sums[i] > best_even) begin
                  best_even = sums[i];
                  even_idx  = AXIS_W'(i);
                  even_ok   = 1'b1;
               end
            end
         end
      end
      found = odd_ok && even_ok;
      if (odd_idx < even_idx) begin
         pair_low  = odd_idx;
         pair_high = even_idx;
      end else begin
         pair_low  = even_idx;
         pair_high = odd_idx;
      end
   end

endmodule

`default_nettype wire
